// File: hdl/elevator_look_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Elevator LOOK scheduler assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_LOOK_SCHEDULER_ASSERT_SVH
`define ELEVATOR_LOOK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ELS_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("elevator_look_scheduler: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ELS_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("elevator_look_scheduler: next-cycle check failed");

`endif

// File: hdl/elev_look_pkg.sv
// ----------------------------------------------------------------------------
// Elevator LOOK scheduler package
// Sizes, codes and sequencer states shared by the scheduler RTL.
// ----------------------------------------------------------------------------
package elev_look_pkg;

   localparam int FLOORS  = 16;
   localparam int SLOTS   = 16;
   localparam int FLOOR_W = 5;
   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int RSP_SLOT_W = 4;
   localparam int TIME_W  = 32;

   localparam logic CMD_ARRIVE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_WAIT  = 2'd1,
      SLOT_RIDE  = 2'd2
   } slot_status_type;

   typedef enum logic [1:0] {
      KIND_ARRIVE = 2'd0,
      KIND_FULL   = 2'd1,
      KIND_FINISH = 2'd2,
      KIND_TICK   = 2'd3
   } rsp_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_SCAN,
      ST_MOVE,
      ST_EMIT,
      ST_REPORT
   } seq_state_type;

   // Pin a requested floor into 1..FLOORS.
   function automatic logic [FLOOR_W-1:0] clamp_floor(input logic [FLOOR_W-1:0] f);
      logic [FLOOR_W-1:0] r;
      r = f;
      if (f == '0) r = FLOOR_W'(1);
      else if (f > FLOOR_W'(FLOORS)) r = FLOOR_W'(FLOORS);
      return r;
   endfunction

endpackage

// File: hdl/elevator_look_scheduler.sv
// ----------------------------------------------------------------------------
// Elevator LOOK scheduler
// Single-car controller: passenger table, slot-serial scan and LOOK move.
// ----------------------------------------------------------------------------
// Usage: raise start with req_command, req_source_floor and req_dest_floor
// while busy is low; the transaction is taken at that clock edge and busy
// stays high until the cycle that shows its last result. Results appear on
// the rsp_ ports for one cycle each, marked by rsp_valid; rsp_last flags the
// final one.
// An arrival: one compare unit walks the slot table, one slot per cycle,
// until it finds the lowest free slot or, past the last slot, reports full.
// A tick runs a scan pass over all slots (board, finish, pending-floor
// compare), a move step, an emit pass over all slots for finish results,
// then the tick report.
// A new transaction may start in the cycle that carries the last result.
// Reset (synchronous) puts the car at floor 1 heading up, the clock at 1 and
// every slot empty. The receiver cannot stall; each result is taken in the
// cycle it is shown.
// ----------------------------------------------------------------------------
module elevator_look_scheduler
   import elev_look_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_command,
   input  logic [FLOOR_W-1:0]    req_source_floor,
   input  logic [FLOOR_W-1:0]    req_dest_floor,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_kind,
   output logic [RSP_SLOT_W-1:0] rsp_passenger_slot,
   output logic [TIME_W-1:0]     rsp_arrival_time,
   output logic [TIME_W-1:0]     rsp_finish_time,
   output logic [FLOOR_W-1:0]    rsp_car_floor,
   output logic                  rsp_moving_up,
   output logic                  rsp_last
);

   // Sequencer
   seq_state_type state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              idx_end;

   // Elevator state
   logic [TIME_W-1:0]  clock_ff, clock_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [FLOOR_W-1:0] car_ff, car_in;
   logic               up_ff, up_in;

   // Passenger table: status and finish marks are control, the rest payload
   slot_status_type    status_ff [SLOTS];
   slot_status_type    status_in [SLOTS];
   logic [SLOTS-1:0]   fin_ff, fin_in;
   logic [FLOOR_W-1:0] source_ff  [SLOTS];
   logic [FLOOR_W-1:0] target_ff  [SLOTS];
   logic [TIME_W-1:0]  arrival_ff [SLOTS];
   logic               slot_wr;

   // Captured request
   logic               cmd_ff, cmd_in;
   logic [FLOOR_W-1:0] src_ff, src_in;
   logic [FLOOR_W-1:0] dst_ff, dst_in;

   // Pending-floor summary gathered over the scan pass
   logic any_ff, any_in;
   logic above_ff, above_in;
   logic below_ff, below_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_kind_type          rsp_kind_ff, rsp_kind_in;
   logic [RSP_SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [TIME_W-1:0]     rsp_arr_ff, rsp_arr_in;
   logic [TIME_W-1:0]     rsp_fin_ff, rsp_fin_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Shared compare unit: one slot per cycle
   slot_status_type    cur_status;
   slot_status_type    upd_status;
   logic               board;
   logic               finish;
   logic [FLOOR_W-1:0] pend_floor;
   logic               ahead;

   logic accept;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign idx_end = (idx_ff == SLOT_W'(SLOTS - 1));

   always_comb begin
      cur_status = status_ff[idx_ff];
      board      = (cur_status == SLOT_WAIT) && (source_ff[idx_ff] == car_ff);
      upd_status = board ? SLOT_RIDE : cur_status;
      finish     = (upd_status == SLOT_RIDE) && (target_ff[idx_ff] == car_ff);
      if (finish) upd_status = SLOT_EMPTY;
      pend_floor = (upd_status == SLOT_WAIT) ? source_ff[idx_ff] : target_ff[idx_ff];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = (req_command == CMD_TICK) ? ST_SCAN : ST_ALLOC;
         end
         ST_ALLOC: begin
            if (cur_status == SLOT_EMPTY || idx_end) state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (idx_end) state_in = ST_MOVE;
         end
         ST_MOVE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (idx_end) state_in = ST_REPORT;
         end
         ST_REPORT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs
   always_comb begin
      idx_in       = idx_ff;
      clock_in     = clock_ff;
      now_in       = now_ff;
      car_in       = car_ff;
      up_in        = up_ff;
      status_in    = status_ff;
      fin_in       = fin_ff;
      slot_wr      = 1'b0;
      cmd_in       = cmd_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      any_in       = any_ff;
      above_in     = above_ff;
      below_in     = below_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_arr_in   = rsp_arr_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_last_in  = rsp_last_ff;
      ahead        = up_ff ? above_ff : below_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Latch the transaction and clear the tick summary
               cmd_in   = req_command;
               src_in   = clamp_floor(req_source_floor);
               dst_in   = clamp_floor(req_dest_floor);
               idx_in   = '0;
               fin_in   = '0;
               any_in   = 1'b0;
               above_in = 1'b0;
               below_in = 1'b0;
            end
         end
         ST_ALLOC: begin
            if (cur_status == SLOT_EMPTY) begin
               // Take the lowest free slot
               status_in[idx_ff] = SLOT_WAIT;
               slot_wr      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ARRIVE;
               rsp_slot_in  = RSP_SLOT_W'(idx_ff);
               rsp_arr_in   = clock_ff;
               rsp_fin_in   = '0;
               rsp_last_in  = 1'b1;
            end else if (idx_end) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FULL;
               rsp_slot_in  = '0;
               rsp_arr_in   = '0;
               rsp_fin_in   = '0;
               rsp_last_in  = 1'b1;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         ST_SCAN: begin
            // Board, finish, then fold this slot into the pending summary
            status_in[idx_ff] = upd_status;
            fin_in[idx_ff]    = finish;
            if (upd_status != SLOT_EMPTY) begin
               any_in = 1'b1;
               if (pend_floor > car_ff) above_in = 1'b1;
               if (pend_floor < car_ff) below_in = 1'b1;
            end
            idx_in = idx_end ? '0 : idx_ff + SLOT_W'(1);
         end
         ST_MOVE: begin
            // Advance the clock, then LOOK: keep heading while work lies ahead
            now_in   = clock_ff;
            clock_in = clock_ff + TIME_W'(1);
            idx_in   = '0;
            if (any_ff) begin
               up_in = ahead ? up_ff : !up_ff;
               if (up_in) begin
                  if (car_ff < FLOOR_W'(FLOORS)) car_in = car_ff + FLOOR_W'(1);
               end else begin
                  if (car_ff > FLOOR_W'(1)) car_in = car_ff - FLOOR_W'(1);
               end
            end
         end
         ST_EMIT: begin
            if (fin_ff[idx_ff]) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FINISH;
               rsp_slot_in  = RSP_SLOT_W'(idx_ff);
               rsp_arr_in   = arrival_ff[idx_ff];
               rsp_fin_in   = now_ff;
               rsp_last_in  = 1'b0;
            end
            idx_in = idx_end ? '0 : idx_ff + SLOT_W'(1);
         end
         ST_REPORT: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_TICK;
            rsp_slot_in  = '0;
            rsp_arr_in   = '0;
            rsp_fin_in   = '0;
            rsp_last_in  = 1'b1;
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         clock_ff     <= TIME_W'(1);
         car_ff       <= FLOOR_W'(1);
         up_ff        <= 1'b1;
         fin_ff       <= '0;
         any_ff       <= 1'b0;
         above_ff     <= 1'b0;
         below_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) status_ff[i] <= SLOT_EMPTY;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         clock_ff     <= clock_in;
         car_ff       <= car_in;
         up_ff        <= up_in;
         fin_ff       <= fin_in;
         any_ff       <= any_in;
         above_ff     <= above_in;
         below_ff     <= below_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      cmd_ff      <= cmd_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_arr_ff  <= rsp_arr_in;
      rsp_fin_ff  <= rsp_fin_in;
      rsp_last_ff <= rsp_last_in;
      if (slot_wr) begin
         source_ff[idx_ff]  <= src_ff;
         target_ff[idx_ff]  <= dst_ff;
         arrival_ff[idx_ff] <= clock_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_passenger_slot = rsp_slot_ff;
   assign rsp_arrival_time   = rsp_arr_ff;
   assign rsp_finish_time    = rsp_fin_ff;
   assign rsp_car_floor      = car_ff;
   assign rsp_moving_up      = up_ff;
   assign rsp_last           = rsp_last_ff;

   // Checks
`include "elevator_look_scheduler_assert.svh"

   // An accepted transaction always holds the block busy next cycle
   `ELS_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   // A non-final result is shown while the block is still busy
   `ELS_ASSERT_NOW(a_more_follow, clock, reset, rsp_valid && !rsp_last, busy)
   // Only finish results are non-final
   `ELS_ASSERT_NOW(a_nonlast_finish, clock, reset, rsp_valid && !rsp_last,
                   rsp_kind == KIND_FINISH)
   // Only an arrival transaction reaches the slot allocation state
   `ELS_ASSERT_NOW(a_cmd_path, clock, reset, state_ff == ST_ALLOC, cmd_ff == CMD_ARRIVE)

endmodule
